// ===== hdl/svpwm_pkg.sv =====
// Shared types and constants of the space-vector PWM duty generator.
// Holds the beat structs, the Horner coefficients and the pipeline depths.
// Depends on nothing.
`default_nettype none

package svpwm_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int DUTY_BITS = 16;
	localparam int CMD_W = 16;
	localparam int FRAC_W = 31;

	localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sd16384;
	localparam logic signed [CMD_W-1:0] CMD_MIN = -16'sd16384;

	localparam logic [FRAC_W-1:0] ONE_Q30 = 31'd1073741824;
	localparam logic [FRAC_W-1:0] S_A1 = 31'd1686629713;
	localparam logic [FRAC_W-1:0] S_A3 = 31'd693598668;
	localparam logic [FRAC_W-1:0] S_A5 = 31'd85569305;
	localparam logic [FRAC_W-1:0] S_A7 = 31'd5026995;
	localparam logic [FRAC_W-1:0] S_A9 = 31'd172272;

	localparam int HORNER_N = 4;
	localparam logic [FRAC_W-1:0] HORNER_COEF [HORNER_N] = '{S_A7, S_A5, S_A3, S_A1};

	localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

	localparam int SC_DEPTH = HORNER_N + 4;
	localparam int PH_DEPTH = 10;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0]    angle;
		logic signed [CMD_W-1:0]  volt_d;
		logic signed [CMD_W-1:0]  volt_q;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0] duty_u;
		logic [DUTY_BITS-1:0] duty_v;
		logic [DUTY_BITS-1:0] duty_w;
	} duty_t;

	typedef struct packed {
		quad_t                    quad;
		logic signed [CMD_W-1:0]  vd;
		logic signed [CMD_W-1:0]  vq;
		logic [FRAC_W-1:0]        z_f;
		logic [FRAC_W-1:0]        z_g;
		logic [FRAC_W-1:0]        z2_f;
		logic [FRAC_W-1:0]        z2_g;
		logic [FRAC_W-1:0]        t_f;
		logic [FRAC_W-1:0]        t_g;
	} horner_t;

	typedef struct packed {
		logic signed [31:0]       sine;
		logic signed [31:0]       cosine;
		logic signed [CMD_W-1:0]  vd;
		logic signed [CMD_W-1:0]  vq;
	} sc_t;

endpackage

`default_nettype wire

// ===== hdl/svpwm_duty_generator.sv =====
// Top level of the space-vector PWM duty generator.
// Depends on svpwm_pkg, svpwm_sincos and svpwm_phase.
//
//   Channel   Ports                     Direction  Handshake
//   command   start, busy, cmd          in         beat taken when start && !busy
//   result    done, result              out        one-cycle strobe, no backpressure
//
// A fully pipelined path takes one command beat every cycle; busy is always low.
// Each result passes through 8 stages for sine and cosine (a row of four Horner
// cells) and 10 for the transforms and duty scaling.
// Reset clears only the valid bits of the pipeline; no result follows a reset.
// The receiver cannot stall, so results leave in command order with no buffering.
`default_nettype none

module svpwm_duty_generator (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire svpwm_pkg::cmd_t      cmd,
	output logic                      done,
	output svpwm_pkg::duty_t          result
);

	localparam int LATENCY = svpwm_pkg::SC_DEPTH + svpwm_pkg::PH_DEPTH;

	logic take;
	logic sc_vld;
	svpwm_pkg::sc_t sc;

	assign busy = 1'b0;
	assign take = start && !busy;

	svpwm_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (take),
		.cmd     (cmd),
		.sc_vld  (sc_vld),
		.sc      (sc)
	);

	svpwm_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.sc_vld (sc_vld),
		.sc     (sc),
		.done   (done),
		.result (result)
	);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##LATENCY done)
		else $error("Accepted beat produced no result.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> ##LATENCY !done)
		else $error("Result without an accepted beat.");

endmodule

`default_nettype wire

// ===== hdl/svpwm_horner_cell.sv =====
// One Horner step of the quarter-sine polynomial for both sine arguments.
// Registers t = coef - (z2 * t) / 2^30 and passes the rest of the beat on.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_horner_cell (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire logic [svpwm_pkg::FRAC_W-1:0]      coef,
	input  wire                                    up_vld,
	input  wire svpwm_pkg::horner_t                up_data,
	output logic                                   dn_vld,
	output svpwm_pkg::horner_t                     dn_data
);

	logic [61:0] prod_f;
	logic [61:0] prod_g;
	logic [31:0] t_f;
	logic [31:0] t_g;
	svpwm_pkg::horner_t nxt;
	logic vld_s1;
	svpwm_pkg::horner_t data_s1;

	always_comb begin
		prod_f = 62'(up_data.z2_f) * 62'(up_data.t_f);
		prod_g = 62'(up_data.z2_g) * 62'(up_data.t_g);
		t_f = 32'(coef) - prod_f[61:30];
		t_g = 32'(coef) - prod_g[61:30];
		nxt = up_data;
		nxt.t_f = t_f[30:0];
		nxt.t_g = t_g[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign dn_vld = vld_s1;
	assign dn_data = data_s1;

endmodule

`default_nettype wire

// ===== hdl/svpwm_sincos.sv =====
// Sine and cosine of the angle, with the D and Q commands clamped alongside.
// A row of Horner cells evaluates the quarter-sine polynomial for both arguments.
// Depends on svpwm_pkg and svpwm_horner_cell.
`default_nettype none

module svpwm_sincos (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cmd_vld,
	input  wire svpwm_pkg::cmd_t      cmd,
	output logic                      sc_vld,
	output svpwm_pkg::sc_t            sc
);

	localparam int AB = svpwm_pkg::ANGLE_BITS;
	localparam int FW = svpwm_pkg::FRAC_W;
	localparam int CW = svpwm_pkg::CMD_W;
	localparam int HN = svpwm_pkg::HORNER_N;

	logic [FW-1:0] f;
	logic signed [CW-1:0] vd_c;
	logic signed [CW-1:0] vq_c;

	logic vld_s1;
	svpwm_pkg::quad_t quad_s1;
	logic signed [CW-1:0] vd_s1;
	logic signed [CW-1:0] vq_s1;
	logic [FW-1:0] zf_s1;
	logic [FW-1:0] zg_s1;

	logic [61:0] sq_f;
	logic [61:0] sq_g;
	logic vld_s2;
	svpwm_pkg::horner_t h_s2;

	logic chain_vld [HN+1];
	svpwm_pkg::horner_t chain_data [HN+1];

	svpwm_pkg::horner_t tail;
	logic [61:0] fin_f;
	logic [61:0] fin_g;
	logic vld_s7;
	svpwm_pkg::quad_t quad_s7;
	logic signed [CW-1:0] vd_s7;
	logic signed [CW-1:0] vq_s7;
	logic [FW-1:0] sf_s7;
	logic [FW-1:0] sg_s7;

	logic signed [31:0] pf;
	logic signed [31:0] pg;
	logic signed [31:0] s_v;
	logic signed [31:0] c_v;
	logic vld_s8;
	svpwm_pkg::sc_t sc_s8;

	always_comb begin
		f = FW'(cmd.angle[AB-3:0]) << (32 - AB);
		if (cmd.volt_d > svpwm_pkg::CMD_MAX) begin
			vd_c = svpwm_pkg::CMD_MAX;
		end else if (cmd.volt_d < svpwm_pkg::CMD_MIN) begin
			vd_c = svpwm_pkg::CMD_MIN;
		end else begin
			vd_c = cmd.volt_d;
		end
		if (cmd.volt_q > svpwm_pkg::CMD_MAX) begin
			vq_c = svpwm_pkg::CMD_MAX;
		end else if (cmd.volt_q < svpwm_pkg::CMD_MIN) begin
			vq_c = svpwm_pkg::CMD_MIN;
		end else begin
			vq_c = cmd.volt_q;
		end
	end

	always_ff @(posedge clk) begin
		quad_s1 <= svpwm_pkg::quad_t'(cmd.angle[AB-1 -: 2]);
		vd_s1 <= vd_c;
		vq_s1 <= vq_c;
		zf_s1 <= f;
		zg_s1 <= svpwm_pkg::ONE_Q30 - f;
	end

	always_comb begin
		sq_f = 62'(zf_s1) * 62'(zf_s1);
		sq_g = 62'(zg_s1) * 62'(zg_s1);
	end

	always_ff @(posedge clk) begin
		h_s2.quad <= quad_s1;
		h_s2.vd <= vd_s1;
		h_s2.vq <= vq_s1;
		h_s2.z_f <= zf_s1;
		h_s2.z_g <= zg_s1;
		h_s2.z2_f <= sq_f[60:30];
		h_s2.z2_g <= sq_g[60:30];
		h_s2.t_f <= svpwm_pkg::S_A9;
		h_s2.t_g <= svpwm_pkg::S_A9;
	end

	assign chain_vld[0] = vld_s2;
	assign chain_data[0] = h_s2;

	for (genvar i = 0; i < HN; i++) begin : g_cell
		svpwm_horner_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.coef    (svpwm_pkg::HORNER_COEF[i]),
			.up_vld  (chain_vld[i]),
			.up_data (chain_data[i]),
			.dn_vld  (chain_vld[i+1]),
			.dn_data (chain_data[i+1])
		);
	end

	always_comb begin
		tail = chain_data[HN];
		fin_f = 62'(tail.z_f) * 62'(tail.t_f);
		fin_g = 62'(tail.z_g) * 62'(tail.t_g);
	end

	always_ff @(posedge clk) begin
		quad_s7 <= tail.quad;
		vd_s7 <= tail.vd;
		vq_s7 <= tail.vq;
		sf_s7 <= (fin_f[61:30] > 32'(svpwm_pkg::ONE_Q30)) ? svpwm_pkg::ONE_Q30 : fin_f[60:30];
		sg_s7 <= (fin_g[61:30] > 32'(svpwm_pkg::ONE_Q30)) ? svpwm_pkg::ONE_Q30 : fin_g[60:30];
	end

	always_comb begin
		pf = 32'(sf_s7);
		pg = 32'(sg_s7);
		case (quad_s7)
			svpwm_pkg::QUAD_I: begin
				s_v = pf;
				c_v = pg;
			end
			svpwm_pkg::QUAD_II: begin
				s_v = pg;
				c_v = -pf;
			end
			svpwm_pkg::QUAD_III: begin
				s_v = -pf;
				c_v = -pg;
			end
			svpwm_pkg::QUAD_IV: begin
				s_v = -pg;
				c_v = pf;
			end
			default: begin
				s_v = pf;
				c_v = pg;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sc_s8.sine <= s_v;
		sc_s8.cosine <= c_v;
		sc_s8.vd <= vd_s7;
		sc_s8.vq <= vq_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= cmd_vld;
			vld_s2 <= vld_s1;
			vld_s7 <= chain_vld[HN];
			vld_s8 <= vld_s7;
		end
	end

	assign sc_vld = vld_s8;
	assign sc = sc_s8;

	a_sine_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> (sf_s7 <= svpwm_pkg::ONE_Q30) && (sg_s7 <= svpwm_pkg::ONE_Q30))
		else $error("Quarter sine exceeds one.");

endmodule

`default_nettype wire

// ===== hdl/svpwm_phase.sv =====
// Inverse Park and Clarke transforms, min-max zero-sequence offset and duty scaling.
// Takes sine, cosine and clamped commands and registers the three duties.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_phase (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       sc_vld,
	input  wire svpwm_pkg::sc_t       sc,
	output logic                      done,
	output svpwm_pkg::duty_t          result
);

	localparam int DB = svpwm_pkg::DUTY_BITS;
	localparam int PW = 48;
	localparam int PH_W = 36;
	localparam int EXT_W = PH_W + 1;
	localparam int D8_W = 38;
	localparam int DUTY_SH = 33 - DB;
	localparam logic signed [D8_W-1:0] FOUR_ONE = D8_W'(64'h1_0000_0000);
	localparam logic signed [D8_W-1:0] DUTY_HALF = D8_W'(64'd1 << (32 - DB));
	localparam logic signed [D8_W-1:0] DMAX = D8_W'((64'd1 << DB) - 64'd1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	logic signed [PW-1:0] dc_s1, qs_s1, ds_s1, qc_s1;
	logic signed [PW-1:0] ar_s2, br_s2;
	logic signed [PW-1:0] a_adj, b_adj;
	logic signed [31:0] alpha_s3, beta_s3;
	logic signed [63:0] pr_s4;
	logic signed [31:0] alpha_s4;
	logic signed [63:0] r_adj;
	logic signed [PH_W-1:0] r_s5;
	logic signed [31:0] alpha_s5;
	logic signed [PH_W-1:0] alpha_x;
	logic signed [PH_W-1:0] ph_s6 [3];
	logic signed [PH_W-1:0] ph_s7 [3];
	logic signed [PH_W-1:0] mx, mn;
	logic signed [PH_W-1:0] mx_s7, mn_s7;
	logic signed [PH_W-1:0] ph_s8 [3];
	logic signed [EXT_W-1:0] ext_s8;
	logic signed [D8_W-1:0] d8_s9 [3];
	svpwm_pkg::duty_t duty_s10;

	function automatic logic [DB-1:0] to_duty(input logic signed [D8_W-1:0] d8);
		logic signed [D8_W-1:0] r;
		r = (d8 + DUTY_HALF) >>> DUTY_SH;
		if (d8 < 0) begin
			return '0;
		end else if (r > DMAX) begin
			return DB'(DMAX);
		end else begin
			return DB'(r);
		end
	endfunction

	always_ff @(posedge clk) begin
		dc_s1 <= PW'(sc.vd) * PW'(sc.cosine);
		qs_s1 <= PW'(sc.vq) * PW'(sc.sine);
		ds_s1 <= PW'(sc.vd) * PW'(sc.sine);
		qc_s1 <= PW'(sc.vq) * PW'(sc.cosine);
	end

	always_ff @(posedge clk) begin
		ar_s2 <= dc_s1 - qs_s1;
		br_s2 <= ds_s1 + qc_s1;
	end

	always_comb begin
		a_adj = ar_s2 + PW'(8192) - PW'(ar_s2[PW-1]);
		b_adj = br_s2 + PW'(8192) - PW'(br_s2[PW-1]);
	end

	always_ff @(posedge clk) begin
		alpha_s3 <= 32'(a_adj >>> 14);
		beta_s3 <= 32'(b_adj >>> 14);
	end

	always_ff @(posedge clk) begin
		pr_s4 <= 64'(beta_s3) * 64'(svpwm_pkg::SQRT3_Q30);
		alpha_s4 <= alpha_s3;
	end

	always_comb begin
		r_adj = pr_s4 + 64'(536870912) - 64'(pr_s4[63]);
	end

	always_ff @(posedge clk) begin
		r_s5 <= PH_W'(r_adj >>> 30);
		alpha_s5 <= alpha_s4;
	end

	always_comb begin
		alpha_x = PH_W'(alpha_s5);
	end

	always_ff @(posedge clk) begin
		ph_s6[0] <= alpha_x + alpha_x;
		ph_s6[1] <= r_s5 - alpha_x;
		ph_s6[2] <= -alpha_x - r_s5;
	end

	always_comb begin
		mx = ph_s6[0];
		if (ph_s6[1] > mx) begin
			mx = ph_s6[1];
		end
		if (ph_s6[2] > mx) begin
			mx = ph_s6[2];
		end
		mn = ph_s6[0];
		if (ph_s6[1] < mn) begin
			mn = ph_s6[1];
		end
		if (ph_s6[2] < mn) begin
			mn = ph_s6[2];
		end
	end

	always_ff @(posedge clk) begin
		ph_s7 <= ph_s6;
		mx_s7 <= mx;
		mn_s7 <= mn;
	end

	always_ff @(posedge clk) begin
		ph_s8 <= ph_s7;
		ext_s8 <= EXT_W'(mx_s7) + EXT_W'(mn_s7);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d8_s9[i] <= FOUR_ONE + (D8_W'(ph_s8[i]) <<< 1) - D8_W'(ext_s8);
		end
	end

	always_ff @(posedge clk) begin
		duty_s10.duty_u <= to_duty(d8_s9[0]);
		duty_s10.duty_v <= to_duty(d8_s9[1]);
		duty_s10.duty_w <= to_duty(d8_s9[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1 <= sc_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	assign done = vld_s10;
	assign result = duty_s10;

	a_phase_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (38'(ph_s6[0]) + 38'(ph_s6[1]) + 38'(ph_s6[2])) == 38'sd0)
		else $error("Phase values do not sum to zero.");

	a_extremes_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> (mx_s7 >= mn_s7) && (mx_s7 >= ph_s7[0]) && (mn_s7 <= ph_s7[0]))
		else $error("Phase maximum and minimum are inconsistent.");

endmodule

`default_nettype wire

// ===== bench/svpwm_duty_generator_tb.sv =====
// Self-checking bench for svpwm_duty_generator: drives command beats, predicts
// every duty triple in fixed point and compares it with each strobed result.
// Depends on svpwm_pkg and the svpwm_duty_generator RTL.
`default_nettype none

module svpwm_duty_generator_tb;

	import svpwm_pkg::*;

	localparam int SETTLE_CYCLES = 40;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	cmd_t  cmd;
	logic  done;
	duty_t result;

	duty_t duty_expected [$];
	int    errors;
	int    idle_pct;

	svpwm_duty_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [63:0] quarter_sine(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] t;
		z2 = (z * z) >> 30;
		t = 64'(S_A9);
		t = 64'(S_A7) - ((z2 * t) >> 30);
		t = 64'(S_A5) - ((z2 * t) >> 30);
		t = 64'(S_A3) - ((z2 * t) >> 30);
		t = 64'(S_A1) - ((z2 * t) >> 30);
		t = (z * t) >> 30;
		if (t > 64'(ONE_Q30)) begin
			t = 64'(ONE_Q30);
		end
		return t;
	endfunction

	function automatic longint round_drop(input longint x, input int n);
		longint half;
		half = longint'(1) << (n - 1);
		if (x >= 0) begin
			return (x + half) >>> n;
		end
		return -(((-x) + half) >>> n);
	endfunction

	function automatic longint clamp_volt(input logic signed [CMD_W-1:0] v);
		longint x;
		x = v;
		if (x > longint'(CMD_MAX)) begin
			x = longint'(CMD_MAX);
		end
		if (x < longint'(CMD_MIN)) begin
			x = longint'(CMD_MIN);
		end
		return x;
	endfunction

	function automatic logic [DUTY_BITS-1:0] scale_duty(input longint x2, input longint ext2);
		longint d8;
		longint r;
		longint dmax;
		dmax = (longint'(1) << DUTY_BITS) - 1;
		d8 = 4 * longint'(ONE_Q30) + 2 * x2 - ext2;
		if (d8 < 0) begin
			return '0;
		end
		r = (d8 + (longint'(1) << (32 - DUTY_BITS))) >>> (33 - DUTY_BITS);
		if (r > dmax) begin
			r = dmax;
		end
		return r[DUTY_BITS-1:0];
	endfunction

	function automatic duty_t predict_duty(input cmd_t c);
		logic [31:0] ph;
		logic [63:0] f;
		longint pf, pg, s, co, vd, vq, alpha, beta, pa, pb, pc, mx, mn;
		duty_t d;
		ph = 32'(c.angle) << (32 - ANGLE_BITS);
		f = 64'(ph[29:0]);
		pf = longint'(quarter_sine(f));
		pg = longint'(quarter_sine(64'(ONE_Q30) - f));
		case (quad_t'(ph[31:30]))
			QUAD_I: begin
				s = pf;
				co = pg;
			end
			QUAD_II: begin
				s = pg;
				co = -pf;
			end
			QUAD_III: begin
				s = -pf;
				co = -pg;
			end
			default: begin
				s = -pg;
				co = pf;
			end
		endcase
		vd = clamp_volt(c.volt_d);
		vq = clamp_volt(c.volt_q);
		alpha = round_drop(vd * co - vq * s, 14);
		beta = round_drop(vd * s + vq * co, 14);
		pa = 2 * alpha;
		pb = -alpha + round_drop(beta * longint'(SQRT3_Q30), 30);
		pc = -pa - pb;
		mx = pa;
		if (pb > mx) mx = pb;
		if (pc > mx) mx = pc;
		mn = pa;
		if (pb < mn) mn = pb;
		if (pc < mn) mn = pc;
		d.duty_u = scale_duty(pa, mx + mn);
		d.duty_v = scale_duty(pb, mx + mn);
		d.duty_w = scale_duty(pc, mx + mn);
		return d;
	endfunction

	task automatic report_field(input string name, input logic [DUTY_BITS-1:0] want,
			input logic [DUTY_BITS-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Command beats are captured and results checked in one process, at the same edge.
	always @(posedge clk) begin : result_check
		duty_t want;
		if (arst_n) begin
			if (start && !busy) begin
				duty_expected.push_back(predict_duty(cmd));
			end
			if (done) begin
				if (duty_expected.size() == 0) begin
					$error("result beat with no command pending");
					errors++;
				end else begin
					want = duty_expected.pop_front();
					report_field("duty_u", want.duty_u, result.duty_u);
					report_field("duty_v", want.duty_v, result.duty_v);
					report_field("duty_w", want.duty_w, result.duty_w);
				end
			end
		end
	end

	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (duty_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [CMD_W-1:0] random_volt();
		logic signed [CMD_W-1:0] v;
		case ($urandom_range(9))
			6, 7: v = CMD_W'($urandom);
			8: begin
				case ($urandom_range(3))
					0: v = CMD_MAX;
					1: v = CMD_MIN;
					2: v = 16'sh7FFF;
					default: v = 16'sh8000;
				endcase
			end
			9: v = CMD_W'(int'($urandom_range(16394, 16374))
					* (($urandom_range(1) != 0) ? 1 : -1));
			default: v = CMD_W'(int'($urandom_range(32768)) - 16384);
		endcase
		return v;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.angle = ANGLE_BITS'($urandom);
		c.volt_d = random_volt();
		c.volt_q = random_volt();
		return c;
	endfunction

	task automatic test_directed_corners();
		idle_pct = 0;
		send_cmd('{16'd0, 16'sd0, 16'sd0});
		send_cmd('{16'd0, 16'sd16384, 16'sd0});
		send_cmd('{16'd16384, 16'sd0, 16'sd16384});
		send_cmd('{16'd32768, -16'sd16384, 16'sd0});
		send_cmd('{16'd49152, 16'sd0, -16'sd16384});
		send_cmd('{16'd65535, 16'sd16384, 16'sd16384});
		send_cmd('{16'd1, -16'sd16384, -16'sd16384});
		send_cmd('{16'd8192, 16'sh7FFF, 16'sh7FFF});
		send_cmd('{16'd24576, 16'sh8000, 16'sh8000});
		send_cmd('{16'd40960, 16'sd16385, -16'sd16385});
		send_cmd('{16'd57344, 16'sh7FFF, 16'sh8000});
		send_cmd('{16'd16383, 16'sd12000, -16'sd9000});
		send_cmd('{16'd32767, 16'sd0, 16'sd16385});
		send_cmd('{16'd49151, -16'sd16385, 16'sd0});
		send_cmd('{16'd10923, 16'sd0, 16'sd18919});
		send_cmd('{16'd21845, 16'sd0, 16'sd14189});
		send_cmd('{16'd43690, 16'sd16384, -16'sd1});
		send_cmd('{16'hFFFF, 16'shFFFF, 16'sh0001});
		send_cmd('{16'hAAAA, 16'sh5555, 16'shAAAA});
		send_cmd('{16'h5555, 16'shAAAA, 16'sh5555});
		drain_results();
	endtask

	task automatic test_random_back_to_back();
		idle_pct = 0;
		repeat (260) send_cmd(random_cmd());
		drain_results();
	endtask

	task automatic test_random_sender_gaps();
		idle_pct = 74;
		repeat (260) send_cmd(random_cmd());
		drain_results();
	endtask

	task automatic test_pause_until_empty();
		idle_pct = 0;
		repeat (15) send_cmd(random_cmd());
		drain_results();
		idle_pct = 50;
		repeat (15) send_cmd(random_cmd());
		drain_results();
	endtask

	task automatic test_random_light_gaps();
		idle_pct = 14;
		repeat (260) send_cmd(random_cmd());
		drain_results();
	endtask

	task automatic test_random_mixed_gaps();
		idle_pct = 0;
		repeat (220) begin
			if ($urandom_range(49) == 0) begin
				idle_pct = ($urandom_range(1) != 0) ? 0 : 74;
			end
			send_cmd(random_cmd());
		end
		drain_results();
	endtask

	initial begin
		errors = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_back_to_back();
		test_random_sender_gaps();
		test_pause_until_empty();
		test_random_light_gaps();
		test_random_mixed_gaps();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
